[hdl/ibp_pkg.sv]
`timescale 1ns / 1ps
package ibp_pkg;

    localparam int WORD_W      = 64;
    localparam int REUSE_W     = 4;
    localparam int SLOT_W      = 21;
    localparam int REUSE_SHIFT = 17;
    localparam int GROUP_SIZE  = 3;
    localparam int BEATS       = GROUP_SIZE + 1;
    localparam int BEAT_W      = $clog2(BEATS);
    localparam int IN_DATA_W   = 72;

    localparam logic [SLOT_W-1:0] SLOT_BASE = SLOT_W'(11'h7E0);
    localparam logic [WORD_W-1:0] NOP_WORD  = 64'h50B0_0000_0007_0F00;

    // bundle queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BEATS - 1);

    // word 0 is the control word, words 1..3 the instructions
    typedef struct packed {
        logic [BEATS-1:0][WORD_W-1:0] word;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // one 21-bit slot of the control word
    function automatic logic [SLOT_W-1:0] slot_value(input logic used,
                                                      input logic [REUSE_W-1:0] reuse);
        logic [SLOT_W-1:0] v;
        v = SLOT_BASE;
        if (used) begin
            v = v | (SLOT_W'(reuse) << REUSE_SHIFT);
        end
        return v;
    endfunction

endpackage

[hdl/ibp_front.sv]
`timescale 1ns / 1ps
module ibp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  logic [ibp_pkg::WORD_W-1:0]     instr_word,
    input  logic [ibp_pkg::REUSE_W-1:0]    reuse_mask,
    input  logic                           final_instr,
    output ibp_pkg::push_t                 push
);
    import ibp_pkg::*;

    logic [WORD_W-1:0]  held_word_reg  [2];
    logic [REUSE_W-1:0] held_reuse_reg [2];
    logic [1:0]         fill_reg, fill_next;
    logic               close;

    logic [GROUP_SIZE-1:0][WORD_W-1:0]  grp_word;
    logic [GROUP_SIZE-1:0][REUSE_W-1:0] grp_reuse;
    logic [GROUP_SIZE-1:0]              grp_used;
    logic [GROUP_SIZE*SLOT_W-1:0]       ctrl_slots;

    // bundle closes on the third item or on a final one
    assign close = final_instr || (fill_reg == 2'd2);

    // assemble the group: held items, then the incoming one, then padding
    always_comb begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
            grp_used[i] = (2'(i) <= fill_reg);
            if (i < 2 && 2'(i) < fill_reg) begin
                grp_word[i]  = held_word_reg[i[0]];
                grp_reuse[i] = held_reuse_reg[i[0]];
            end else if (2'(i) == fill_reg) begin
                grp_word[i]  = instr_word;
                grp_reuse[i] = reuse_mask;
            end else begin
                grp_word[i]  = NOP_WORD;
                grp_reuse[i] = '0;
            end
            ctrl_slots[i*SLOT_W +: SLOT_W] = slot_value(grp_used[i], grp_reuse[i]);
        end
    end

    always_comb begin
        push.valid          = in_accept && close;
        push.bundle.word[0] = WORD_W'(ctrl_slots);
        for (int i = 0; i < GROUP_SIZE; i++) begin
            push.bundle.word[i+1] = grp_word[i];
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (in_accept) begin
            fill_next = close ? 2'd0 : fill_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // held items, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept && !close) begin
            held_word_reg[fill_reg[0]]  <= instr_word;
            held_reuse_reg[fill_reg[0]] <= reuse_mask;
        end
    end

endmodule

[hdl/ibp_queue.sv]
`timescale 1ns / 1ps
module ibp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  ibp_pkg::push_t    push,
    input  logic              pop,
    output ibp_pkg::bundle_t  head,
    output ibp_pkg::qstat_t   stat
);
    import ibp_pkg::*;

    bundle_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push.valid) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.bundle;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push.valid)
        else $error("bundle pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.empty |-> !pop)
        else $error("bundle popped from empty queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy out of range");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue occupancy missed a push");
`endif

endmodule

[hdl/ibp_back.sv]
`timescale 1ns / 1ps
module ibp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ibp_pkg::bundle_t            head,
    input  ibp_pkg::qstat_t             stat,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ibp_pkg::WORD_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import ibp_pkg::*;

    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic              load;

    // output register refills when the queue holds a bundle and the register is empty or being taken
    assign load = !stat.empty && (!valid_reg || m_tready);
    assign pop  = load && (beat_reg == LAST_BEAT);

    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = (beat_reg == LAST_BEAT) ? '0 : beat_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= head.word[beat_reg];
            last_reg <= (beat_reg == LAST_BEAT);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tlast  = last_reg;

endmodule

[hdl/instruction_bundle_packer.sv]
`timescale 1ns / 1ps
// Packs 64-bit instruction words into four-word bundles: a control word with
// three 21-bit reuse slots, then three instruction words, NOP padded when a
// final item closes a partial group; m_tlast marks the fourth word. The input
// side takes one item per cycle while the two-entry bundle queue has room; the
// output side sends one word per cycle from a single-word output register
// while m_tready is high and the queue holds a bundle. A bundle's first word
// is written into a queue entry and then into the output register before it
// leaves.
module instruction_bundle_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // instr_word[63:0], reuse_mask[67:64], zero pad
    input  logic        s_tlast,   // final_instr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_word[63:0]
    output logic        m_tlast    // bundle_end
);
    import ibp_pkg::*;

    push_t   push;
    bundle_t head;
    qstat_t  stat;
    logic    pop;
    logic    in_accept;

    assign s_tready  = !stat.full;
    assign in_accept = s_tvalid && s_tready;

    ibp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .instr_word  (s_tdata[WORD_W-1:0]),
        .reuse_mask  (s_tdata[WORD_W +: REUSE_W]),
        .final_instr (s_tlast),
        .push        (push)
    );

    ibp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    ibp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
